// ===== hdl/pls_pkg.sv =====
`timescale 1ns / 1ps

package pls_pkg;

   // Field widths of the channel interface.
   localparam int CHAN_W    = 6;
   localparam int LEVEL_W   = 8;
   localparam int TABLE_W   = 48;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   localparam int NUM_CHANNELS_DEF = 6;

   // Register indexes; each register sits at byte address 8 * index.
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOAD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRIORITY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_CODE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MED_CODE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT   = 3'd6;

   // Reset values of the registers.
   localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 8'd95;
   localparam logic [LEVEL_W-1:0] LOW_CODE_RST  = 8'd1;
   localparam logic [LEVEL_W-1:0] MED_CODE_RST  = 8'd2;
   localparam logic [LEVEL_W-1:0] TIMEOUT_RST   = 8'd75;

   typedef struct packed {
      logic               enable;
      logic [LEVEL_W-1:0] threshold;
      logic [TABLE_W-1:0] load_table;
      logic [TABLE_W-1:0] priority_table;
      logic [LEVEL_W-1:0] low_code;
      logic [LEVEL_W-1:0] med_code;
      logic [LEVEL_W-1:0] timeout;
   } cfg_type;

endpackage

// ===== hdl/pls_csr.sv =====
`timescale 1ns / 1ps

module pls_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pls_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pls_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pls_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output pls_pkg::cfg_type                  cfg
);

   pls_pkg::cfg_type                 cfg_ff;
   logic [pls_pkg::CSR_IDX_W-1:0]    idx;
   logic                             wr_en;

   assign idx        = csr_paddr[pls_pkg::CSR_ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= 1'b0;
         cfg_ff.threshold      <= pls_pkg::THRESHOLD_RST;
         cfg_ff.load_table     <= '0;
         cfg_ff.priority_table <= '0;
         cfg_ff.low_code       <= pls_pkg::LOW_CODE_RST;
         cfg_ff.med_code       <= pls_pkg::MED_CODE_RST;
         cfg_ff.timeout        <= pls_pkg::TIMEOUT_RST;
      end else if (wr_en) begin
         case (idx)
            pls_pkg::REG_ENABLE:    cfg_ff.enable         <= csr_pwdata[0];
            pls_pkg::REG_THRESHOLD: cfg_ff.threshold      <= csr_pwdata[pls_pkg::LEVEL_W-1:0];
            pls_pkg::REG_LOAD:      cfg_ff.load_table     <= csr_pwdata[pls_pkg::TABLE_W-1:0];
            pls_pkg::REG_PRIORITY:  cfg_ff.priority_table <= csr_pwdata[pls_pkg::TABLE_W-1:0];
            pls_pkg::REG_LOW_CODE:  cfg_ff.low_code       <= csr_pwdata[pls_pkg::LEVEL_W-1:0];
            pls_pkg::REG_MED_CODE:  cfg_ff.med_code       <= csr_pwdata[pls_pkg::LEVEL_W-1:0];
            pls_pkg::REG_TIMEOUT:   cfg_ff.timeout        <= csr_pwdata[pls_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Reads return the register contents, zero-extended.
   always_comb begin
      csr_prdata = '0;
      case (idx)
         pls_pkg::REG_ENABLE:    csr_prdata = pls_pkg::CSR_DATA_W'(cfg_ff.enable);
         pls_pkg::REG_THRESHOLD: csr_prdata = pls_pkg::CSR_DATA_W'(cfg_ff.threshold);
         pls_pkg::REG_LOAD:      csr_prdata = pls_pkg::CSR_DATA_W'(cfg_ff.load_table);
         pls_pkg::REG_PRIORITY:  csr_prdata = pls_pkg::CSR_DATA_W'(cfg_ff.priority_table);
         pls_pkg::REG_LOW_CODE:  csr_prdata = pls_pkg::CSR_DATA_W'(cfg_ff.low_code);
         pls_pkg::REG_MED_CODE:  csr_prdata = pls_pkg::CSR_DATA_W'(cfg_ff.med_code);
         pls_pkg::REG_TIMEOUT:   csr_prdata = pls_pkg::CSR_DATA_W'(cfg_ff.timeout);
         default:                csr_prdata = '0;
      endcase
   end

endmodule

// ===== hdl/priority_load_shedder.sv =====
`timescale 1ns / 1ps
// Sequencer: a disabled or short silent tick goes straight to the finish state; a restore
// scans the channels once, an overload shed scans them in a low and a medium pass, and a
// timed-out tick first sums the loads and then sheds. One transaction at a time: no new tick
// is taken until the sequencer is idle again, and it waits while a result is held back.
// Reset: synchronous, active high; clears the shed flags, the silence counter, the sequencer
// and the result valid, and loads the registers with their documented reset values.

module priority_load_shedder #(
   parameter int NUM_CHANNELS = pls_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Tick input channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_reading_valid,
   input  logic [pls_pkg::LEVEL_W-1:0]       req_power_reading,
   input  logic [pls_pkg::CHAN_W-1:0]        req_channels_on,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pls_pkg::CHAN_W-1:0]        rsp_turn_off_mask,
   output logic [pls_pkg::CHAN_W-1:0]        rsp_turn_on_mask,
   output logic [pls_pkg::CHAN_W-1:0]        rsp_shed_mask,
   output logic                              rsp_data_timed_out,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pls_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pls_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pls_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // The channel index counts 0 .. NUM_CHANNELS-1 and needs at least one bit.
   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
   localparam logic [pls_pkg::CHAN_W-1:0] CHAN_MASK =
      pls_pkg::CHAN_W'((1 << NUM_CHANNELS) - 1);
   // The load estimate holds the sum of NUM_CHANNELS eight-bit loads.
   localparam int SUM_W = pls_pkg::LEVEL_W + $clog2(NUM_CHANNELS + 1);
   localparam logic [pls_pkg::LEVEL_W-1:0] COUNT_MAX = '1;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SUM     = 3'd1;
   localparam logic [2:0] ST_SHED    = 3'd2;
   localparam logic [2:0] ST_RESTORE = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   pls_pkg::cfg_type cfg;

   pls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Control state.
   logic [2:0]                     state_ff, state_in;
   logic [CH_W-1:0]                ch_ff, ch_in;
   logic                           pass_med_ff, pass_med_in;
   logic                           est_ff, est_in;
   logic [pls_pkg::CHAN_W-1:0]     flags_ff, flags_in;
   logic [pls_pkg::LEVEL_W-1:0]    count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   // Working registers of the transaction in flight.
   logic [pls_pkg::CHAN_W-1:0]     on_ff, on_in;
   logic [pls_pkg::CHAN_W-1:0]     off_ff, off_in;
   logic [pls_pkg::CHAN_W-1:0]     turn_on_ff, turn_on_in;
   logic                           timed_ff, timed_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [pls_pkg::LEVEL_W-1:0]    reading_ff, reading_in;
   // Result registers.
   logic [pls_pkg::CHAN_W-1:0]     rsp_off_ff, rsp_off_in;
   logic [pls_pkg::CHAN_W-1:0]     rsp_on_ff, rsp_on_in;
   logic [pls_pkg::CHAN_W-1:0]     rsp_shed_ff, rsp_shed_in;
   logic                           rsp_timed_ff, rsp_timed_in;

   // The shared datapath: the load and priority of the channel under the index, the restore
   // adder and the compares that the scan steps use.
   logic [pls_pkg::LEVEL_W-1:0]    ch_load;
   logic [pls_pkg::LEVEL_W-1:0]    ch_prio;
   logic [pls_pkg::LEVEL_W-1:0]    pass_code;
   logic [pls_pkg::LEVEL_W:0]      restore_sum;
   logic                           over;
   logic                           prio_hit;
   logic                           last;
   logic [pls_pkg::LEVEL_W-1:0]    count_next;

   assign ch_load     = cfg.load_table[ch_ff * pls_pkg::LEVEL_W +: pls_pkg::LEVEL_W];
   assign ch_prio     = cfg.priority_table[ch_ff * pls_pkg::LEVEL_W +: pls_pkg::LEVEL_W];
   assign pass_code   = pass_med_ff ? cfg.med_code : cfg.low_code;
   assign prio_hit    = on_ff[ch_ff] && (ch_prio == pass_code);
   assign restore_sum = {1'b0, reading_ff} + {1'b0, ch_load};
   // In a timed-out tick shedding only goes on while the estimate exceeds the threshold.
   assign over        = !est_ff || (sum_ff > SUM_W'(cfg.threshold));
   assign last        = (ch_ff == LAST_CH);
   assign count_next  = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 1'b1;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      pass_med_in  = pass_med_ff;
      est_in       = est_ff;
      flags_in     = flags_ff;
      count_in     = count_ff;
      on_in        = on_ff;
      off_in       = off_ff;
      turn_on_in   = turn_on_ff;
      timed_in     = timed_ff;
      sum_in       = sum_ff;
      reading_in   = reading_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_shed_in  = rsp_shed_ff;
      rsp_timed_in = rsp_timed_ff;

      // A result that the consumer took frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Latch the tick and decide which scan it needs.
               on_in       = req_channels_on & CHAN_MASK;
               off_in      = '0;
               turn_on_in  = '0;
               timed_in    = 1'b0;
               sum_in      = '0;
               reading_in  = req_power_reading;
               ch_in       = '0;
               pass_med_in = 1'b0;
               est_in      = 1'b0;
               if (!cfg.enable) begin
                  state_in = ST_FINISH;
               end else if (req_reading_valid) begin
                  count_in = '0;
                  if (req_power_reading > cfg.threshold) begin
                     state_in = ST_SHED;
                  end else begin
                     state_in = ST_RESTORE;
                  end
               end else if (count_next >= cfg.timeout) begin
                  // Silence has lasted long enough: estimate the load from the table.
                  count_in = cfg.timeout;
                  timed_in = 1'b1;
                  est_in   = 1'b1;
                  state_in = ST_SUM;
               end else begin
                  count_in = count_next;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SUM: begin
            if (on_ff[ch_ff]) begin
               sum_in = sum_ff + SUM_W'(ch_load);
            end
            if (last) begin
               ch_in    = '0;
               state_in = ST_SHED;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_SHED: begin
            if (prio_hit && over) begin
               on_in    = on_ff & ~(pls_pkg::CHAN_W'(1) << ch_ff);
               off_in   = off_ff | (pls_pkg::CHAN_W'(1) << ch_ff);
               flags_in = flags_ff | (pls_pkg::CHAN_W'(1) << ch_ff);
               if (est_ff) begin
                  sum_in = sum_ff - SUM_W'(ch_load);
               end
            end
            if (!est_ff && prio_hit) begin
               // A reading above the threshold sheds one channel only.
               state_in = ST_FINISH;
            end else if (!over) begin
               // The estimate is low enough; the medium pass would not shed either.
               state_in = ST_FINISH;
            end else if (last) begin
               if (!pass_med_ff) begin
                  pass_med_in = 1'b1;
                  ch_in       = '0;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_RESTORE: begin
            // Bring back the first shed channel whose load keeps the total below threshold.
            if (flags_ff[ch_ff] && (restore_sum < {1'b0, cfg.threshold})) begin
               turn_on_in = pls_pkg::CHAN_W'(1) << ch_ff;
               flags_in   = flags_ff & ~(pls_pkg::CHAN_W'(1) << ch_ff);
               state_in   = ST_FINISH;
            end else if (last) begin
               state_in = ST_FINISH;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = off_ff & CHAN_MASK;
               rsp_on_in    = turn_on_ff & CHAN_MASK;
               rsp_shed_in  = flags_ff & CHAN_MASK;
               rsp_timed_in = timed_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         pass_med_ff  <= 1'b0;
         est_ff       <= 1'b0;
         flags_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         pass_med_ff  <= pass_med_in;
         est_ff       <= est_in;
         flags_ff     <= flags_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      on_ff        <= on_in;
      off_ff       <= off_in;
      turn_on_ff   <= turn_on_in;
      timed_ff     <= timed_in;
      sum_ff       <= sum_in;
      reading_ff   <= reading_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_on_ff    <= rsp_on_in;
      rsp_shed_ff  <= rsp_shed_in;
      rsp_timed_ff <= rsp_timed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_turn_off_mask  = rsp_off_ff;
   assign rsp_turn_on_mask   = rsp_on_ff;
   assign rsp_shed_mask      = rsp_shed_ff;
   assign rsp_data_timed_out = rsp_timed_ff;

   // An accepted transaction always moves the sequencer out of idle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after an accepted transaction");

   // A restore turns on at most one channel.
   a_one_restore: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_turn_on_mask))
      else $error("more than one channel restored in one transaction");

   // A channel is never switched off and on in the same transaction.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_turn_off_mask & rsp_turn_on_mask) == '0))
      else $error("channel switched off and on in one transaction");

   // A timed-out tick only sheds and never restores.
   a_timeout_no_restore: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_timed_out) |-> (rsp_turn_on_mask == '0))
      else $error("restore reported on a timed-out transaction");

endmodule
